/* rtl/rfps_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the RGB fade pattern sequencer.
package rfps_pkg;

  localparam int STEPS_DEFAULT    = 16;
  localparam int PATTERNS_DEFAULT = 8;

  localparam logic [15:0] FADE_MAX  = 16'hFFFF;
  localparam logic [7:0]  TIMER_MAX = 8'hFF;
  localparam logic [3:0]  DIVIDER_RESET = 4'd2;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_W      = 4;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_FAST  = 2'd1,
    MODE_SLOW  = 2'd2,
    MODE_NONE  = 2'd3
  } item_mode_t;

  typedef enum logic [1:0] {
    CH_HOLD = 2'd0,
    CH_OFF  = 2'd1,
    CH_UP   = 2'd2,
    CH_DOWN = 2'd3
  } chan_mode_t;

  typedef enum logic {
    CFG_ENABLE  = 1'b0,
    CFG_DIVIDER = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_NEXT
  } seq_state_t;

  // One table step, bit layout as stored in the pattern memory
  typedef struct packed {
    logic       last;
    logic [7:0] duration;
    logic [5:0] modes;
    logic [7:0] blue_goal;
    logic [7:0] green_goal;
    logic [7:0] red_goal;
    logic [7:0] blue_start;
    logic [7:0] green_start;
    logic [7:0] red_start;
  } step_entry_t;

  localparam int ENTRY_W = $bits(step_entry_t);

endpackage

/* rtl/rfps_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module rfps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/rfps_duty.sv */
`timescale 1ns / 1ps
// Per-channel duty computation from one step entry and the fade counter.
module rfps_duty (
  input  rfps_pkg::step_entry_t entry,
  input  logic [15:0]           fade,
  output logic [23:0]           duties
);

  function automatic logic [7:0] chan_duty(input logic [1:0] cm, input logic [7:0] st,
                                           input logic [7:0] gl, input logic [15:0] fc);
    logic [16:0] up;
    logic [7:0]  span;
    logic [7:0]  res;
    up   = {1'b0, fc} + {9'd0, st};
    span = st - gl;
    unique case (rfps_pkg::chan_mode_t'(cm))
      rfps_pkg::CH_HOLD: res = st;
      rfps_pkg::CH_OFF:  res = st;
      rfps_pkg::CH_UP:   res = (up > {9'd0, gl}) ? gl : up[7:0];
      rfps_pkg::CH_DOWN: begin
        // goal at once when already below it or the fade overshoots
        if (st < gl || fc > {8'd0, span}) res = gl;
        else res = st - fc[7:0];
      end
    endcase
    return res;
  endfunction

  assign duties[7:0]   = chan_duty(entry.modes[1:0], entry.red_start, entry.red_goal, fade);
  assign duties[15:8]  = chan_duty(entry.modes[3:2], entry.green_start, entry.green_goal, fade);
  assign duties[23:16] = chan_duty(entry.modes[5:4], entry.blue_start, entry.blue_goal, fade);

endmodule

/* rtl/rgb_fade_pattern_sequencer.sv */
`timescale 1ns / 1ps
// RGB fade pattern sequencer: request channel, pattern memory, sequencer FSM.
//
// Requests enter on s_* (tuser = kind: table write, fast tick, slow tick, none).
// A table write stores one step of one pattern; a fast tick advances the
// fade prescaler and runs the sequencer; a slow tick advances the step timer.
// Every request gives exactly one result on m_*: the three duties (zero when
// disabled) and the step counter after the request.
// Writes, slow ticks and disabled fast ticks load the output register in the
// cycle they are accepted. An enabled fast tick reads the pattern memory
// (registered read) and evaluates the step in ST_EVAL, then in ST_NEXT, when
// the step ends, reads the next step's start duties from the memory's single
// read port. One request is in flight at a time; the result sits in an output
// register, and s_tready stays low while it holds a result not yet taken.
// Reset (rst, synchronous) clears the sequencer state, disables the LEDs and
// arms a restart at step 0; the pattern memory is not cleared and must be
// written before it is played. Configuration is written through cfg_*.
module rgb_fade_pattern_sequencer #(
  parameter int STEPS_PER_PATTERN = rfps_pkg::STEPS_DEFAULT,
  parameter int PATTERN_COUNT     = rfps_pkg::PATTERNS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // pattern_select, step_index, red_start, green_start, blue_start, red_goal,
  // green_goal, blue_goal, channel_modes, step_duration, zero pad
  input  logic [rfps_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [1:0]                      s_tuser,  // mode
  input  logic                            s_tlast,  // last_step
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // red_duty, green_duty, blue_duty, current_step, zero pad
  output logic [rfps_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [rfps_pkg::CFG_W-1:0]      cfg_data
);

  localparam int DEPTH = PATTERN_COUNT * STEPS_PER_PATTERN;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(STEPS_PER_PATTERN + 1);

  function automatic logic [AW-1:0] addr_of(input logic [2:0] pat, input logic [SW-1:0] step);
    return AW'(32'(pat) * STEPS_PER_PATTERN + 32'(step));
  endfunction

  function automatic logic [2:0] clamp_pat(input logic [2:0] sel);
    return (32'(sel) < PATTERN_COUNT) ? sel : 3'(PATTERN_COUNT - 1);
  endfunction

  rfps_pkg::seq_state_t state, state_next;

  logic              led_enable;
  logic [3:0]        ramp_divider;
  logic [SW-1:0]     step_counter, step_counter_next;
  logic [7:0]        step_timer, step_timer_next;
  logic [15:0]       fade_counter, fade_counter_next;
  logic [3:0]        tick_divider, tick_divider_next;
  logic [2:0]        previous_pattern, previous_pattern_next;
  logic              restart_pending, restart_pending_next;
  logic [23:0]       held, held_next;
  logic [2:0]        pat, pat_next;
  logic              m_tvalid_next;

  logic                  accept;
  logic                  out_load;
  logic                  ram_we;
  logic [AW-1:0]         raddr;
  logic [rfps_pkg::ENTRY_W-1:0] rdata;
  rfps_pkg::step_entry_t entry;
  rfps_pkg::step_entry_t wr_entry;
  logic [23:0]           duties;
  logic [2:0]            in_sel;
  logic [3:0]            in_idx;
  logic [3:0]            div_eff;
  logic [3:0]            td_inc;
  logic [SW-1:0]         step_inc;
  logic                  restart_now;
  logic                  wr_ok;

  assign in_sel   = s_tdata[2:0];
  assign in_idx   = s_tdata[6:3];
  assign wr_entry = rfps_pkg::step_entry_t'({s_tlast, s_tdata[68:7]});
  assign wr_ok    = (32'(in_sel) < PATTERN_COUNT) && (32'(in_idx) < STEPS_PER_PATTERN);
  assign entry    = rfps_pkg::step_entry_t'(rdata);

  assign div_eff  = (ramp_divider == 4'd0) ? 4'd1 : ramp_divider;
  assign td_inc   = tick_divider + 4'd1;
  assign step_inc = step_counter + SW'(1);

  assign s_tready = (state == rfps_pkg::ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  rfps_ram #(
    .WIDTH(rfps_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr_of(in_sel, SW'(in_idx))),
    .wdata(wr_entry),
    .raddr(raddr),
    .rdata(rdata)
  );

  rfps_duty u_duty (
    .entry (entry),
    .fade  (fade_counter),
    .duties(duties)
  );

  always_comb begin
    state_next            = state;
    step_counter_next     = step_counter;
    step_timer_next       = step_timer;
    fade_counter_next     = fade_counter;
    tick_divider_next     = tick_divider;
    previous_pattern_next = previous_pattern;
    restart_pending_next  = restart_pending;
    held_next             = held;
    pat_next              = pat;
    out_load              = 1'b0;
    ram_we                = 1'b0;
    raddr                 = addr_of(pat, step_inc);
    restart_now           = restart_pending || (previous_pattern != in_sel);

    unique case (state)
      rfps_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (rfps_pkg::item_mode_t'(s_tuser))
            rfps_pkg::MODE_WRITE: begin
              ram_we   = wr_ok;
              out_load = 1'b1;
            end
            rfps_pkg::MODE_FAST: begin
              if (td_inc >= div_eff) begin
                tick_divider_next = 4'd0;
                if (fade_counter < rfps_pkg::FADE_MAX) begin
                  fade_counter_next = fade_counter + 16'd1;
                end
              end else begin
                tick_divider_next = td_inc;
              end
              if (led_enable) begin
                previous_pattern_next = in_sel;
                restart_pending_next  = restart_now;
                pat_next              = clamp_pat(in_sel);
                raddr      = addr_of(clamp_pat(in_sel), restart_now ? '0 : step_counter);
                state_next = rfps_pkg::ST_EVAL;
              end else begin
                out_load = 1'b1;
              end
            end
            rfps_pkg::MODE_SLOW: begin
              if (step_timer < rfps_pkg::TIMER_MAX) begin
                step_timer_next = step_timer + 8'd1;
              end
              out_load = 1'b1;
            end
            rfps_pkg::MODE_NONE: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      rfps_pkg::ST_EVAL: begin
        if (restart_pending) begin
          step_timer_next      = 8'd0;
          fade_counter_next    = 16'd0;
          step_counter_next    = '0;
          held_next            = entry[23:0];
          restart_pending_next = 1'b0;
          out_load             = 1'b1;
          state_next           = rfps_pkg::ST_IDLE;
        end else if (step_timer >= entry.duration) begin
          step_counter_next = step_inc;
          if (entry.last || 32'(step_inc) >= STEPS_PER_PATTERN) begin
            // past the end: keep this tick's duties, restart on the next tick
            restart_pending_next = 1'b1;
            held_next            = duties;
            out_load             = 1'b1;
            state_next           = rfps_pkg::ST_IDLE;
          end else begin
            step_timer_next   = 8'd0;
            fade_counter_next = 16'd0;
            raddr             = addr_of(pat, step_inc);
            state_next        = rfps_pkg::ST_NEXT;
          end
        end else begin
          held_next  = duties;
          out_load   = 1'b1;
          state_next = rfps_pkg::ST_IDLE;
        end
      end
      rfps_pkg::ST_NEXT: begin
        held_next  = entry[23:0];
        out_load   = 1'b1;
        state_next = rfps_pkg::ST_IDLE;
      end
      default: state_next = rfps_pkg::ST_IDLE;
    endcase

    if (out_load) m_tvalid_next = 1'b1;
    else if (m_tready) m_tvalid_next = 1'b0;
    else m_tvalid_next = m_tvalid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= rfps_pkg::ST_IDLE;
      led_enable       <= 1'b0;
      ramp_divider     <= rfps_pkg::DIVIDER_RESET;
      step_counter     <= '0;
      step_timer       <= 8'd0;
      fade_counter     <= 16'd0;
      tick_divider     <= 4'd0;
      previous_pattern <= 3'd0;
      restart_pending  <= 1'b1;
      held             <= 24'd0;
      pat              <= 3'd0;
      m_tvalid         <= 1'b0;
    end else begin
      state            <= state_next;
      step_counter     <= step_counter_next;
      step_timer       <= step_timer_next;
      fade_counter     <= fade_counter_next;
      tick_divider     <= tick_divider_next;
      previous_pattern <= previous_pattern_next;
      restart_pending  <= restart_pending_next;
      held             <= held_next;
      pat              <= pat_next;
      m_tvalid         <= m_tvalid_next;
      if (cfg_we) begin
        unique case (rfps_pkg::cfg_index_t'(cfg_index))
          rfps_pkg::CFG_ENABLE:  led_enable   <= cfg_data[0];
          rfps_pkg::CFG_DIVIDER: ramp_divider <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'd0, 5'(step_counter_next), led_enable ? held_next : 24'd0};
    end
  end

endmodule
